// ===== design/mma_pkg.sv =====
// Package for the matrix multiply-accumulate block.
// Holds item structs, register indexes, mode and state codes and width helpers.
// Used by mma_dp, mma_ctrl and the top level.
package mma_pkg;

    localparam int MAX_DIM_DEF  = 64;
    localparam int RESULT_LIMIT = 64;
    localparam int VAL_W        = 16;
    localparam int IDX_W        = 6;
    localparam int DIMCFG_W     = 7;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 16;
    localparam int MUL_W        = 17;
    localparam int PROD_W       = 2 * MUL_W;
    localparam int CHUNK_W      = 16;
    localparam logic [DIMCFG_W-1:0] DRAIN_LAST = 7'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_TRANSPOSE_A = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TRANSPOSE_B = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS_M      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS_N      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_INNER_K     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA       = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_BETA        = 3'd6;

    typedef enum logic [1:0] {
        MODE_LOAD_A  = 2'd0,
        MODE_LOAD_B  = 2'd1,
        MODE_LOAD_C  = 2'd2,
        MODE_COMPUTE = 2'd3
    } t_mode;

    typedef struct packed {
        t_mode                    mode;
        logic [IDX_W-1:0]         row;
        logic [IDX_W-1:0]         col;
        logic signed [VAL_W-1:0]  value;
    } t_in_item;

    typedef struct packed {
        logic [IDX_W-1:0]         out_row;
        logic [IDX_W-1:0]         out_col;
        logic signed [VAL_W-1:0]  out_value;
        logic                     last;
    } t_out_item;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_MAC,
        OP_TOP,
        OP_LOW,
        OP_BETA
    } t_op;

    typedef struct packed {
        t_op  op;
        logic clr;
    } t_ctl;

    typedef enum logic [3:0] {
        S_IDLE,
        S_START,
        S_MAC,
        S_DRAIN1,
        S_TOP,
        S_LOW,
        S_BETA,
        S_DRAIN2,
        S_OUT
    } t_state;

    function automatic int dim_width(input int max_dim);
        return (max_dim > 1) ? $clog2(max_dim) : 1;
    endfunction

    function automatic int acc_width(input int max_dim);
        return 32 + dim_width(max_dim);
    endfunction

    function automatic int chunk_count(input int max_dim);
        return (acc_width(max_dim) + CHUNK_W - 1) / CHUNK_W;
    endfunction

endpackage

// ===== design/mma_ram.sv =====
// Single-port-write, single-port-read memory with registered read data.
// Holds one element store; depends on nothing else.
module mma_ram #(
    parameter int AW = 12,
    parameter int DW = 16
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [2**AW];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/mma_dp.sv =====
// Arithmetic datapath: one shared 17x17 multiplier, product accumulator,
// alpha and beta scaling and saturation. Depends on mma_pkg.
module mma_dp #(
    parameter int MAX_DIM = mma_pkg::MAX_DIM_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  mma_pkg::t_ctl                      i_ctl,
    input  logic signed [mma_pkg::VAL_W-1:0]   i_rd_a,
    input  logic signed [mma_pkg::VAL_W-1:0]   i_rd_b,
    input  logic signed [mma_pkg::VAL_W-1:0]   i_rd_c,
    input  logic signed [mma_pkg::VAL_W-1:0]   i_alpha,
    input  logic signed [mma_pkg::VAL_W-1:0]   i_beta,
    output logic signed [mma_pkg::VAL_W-1:0]   o_total
);
    import mma_pkg::*;

    localparam int ACC_W = acc_width(MAX_DIM);
    localparam int NCH   = chunk_count(MAX_DIM);
    localparam int XW    = CHUNK_W * NCH;
    localparam int LOW_W = XW - CHUNK_W;
    localparam int SC_W  = XW + VAL_W;
    localparam int HI_W  = SC_W - 16;
    localparam int BC_W  = 32;
    localparam int SUM_W = HI_W + 1;
    localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(32767);
    localparam logic signed [SUM_W-1:0] SAT_LO = SUM_W'(-32768);

    t_op                       r_op1;
    t_op                       r_op2;
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [ACC_W-1:0]   r_acc;
    logic signed [SC_W-1:0]    r_sc;
    logic signed [BC_W-1:0]    r_bc;
    logic [LOW_W-1:0]          r_sh;

    logic signed [XW-1:0]      acc_x;
    logic signed [MUL_W-1:0]   mul_a;
    logic signed [MUL_W-1:0]   mul_b;
    logic signed [PROD_W-1:0]  mul_p;
    logic signed [HI_W-1:0]    hi_term;
    logic signed [23:0]        lo_term;
    logic signed [SUM_W-1:0]   sum;

    assign acc_x = XW'(r_acc);

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_op1)
            OP_MAC: begin
                mul_a = MUL_W'(i_rd_a);
                mul_b = MUL_W'(i_rd_b);
            end
            OP_TOP: begin
                mul_a = MUL_W'(i_alpha);
                mul_b = MUL_W'($signed(acc_x[XW-1 -: CHUNK_W]));
            end
            OP_LOW: begin
                mul_a = MUL_W'(i_alpha);
                mul_b = $signed({1'b0, r_sh[LOW_W-1 -: CHUNK_W]});
            end
            OP_BETA: begin
                mul_a = MUL_W'(i_beta);
                mul_b = MUL_W'(i_rd_c);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op1 <= OP_NONE;
            r_op2 <= OP_NONE;
        end else begin
            r_op1 <= i_ctl.op;
            r_op2 <= r_op1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_p;
        if (r_op1 == OP_TOP) begin
            r_sh <= acc_x[LOW_W-1:0];
        end else if (r_op1 == OP_LOW) begin
            r_sh <= r_sh << CHUNK_W;
        end
        case (r_op2)
            OP_MAC:  r_acc <= r_acc + ACC_W'(r_prod);
            OP_TOP:  r_sc  <= SC_W'(r_prod);
            OP_LOW:  r_sc  <= (r_sc <<< CHUNK_W) + SC_W'(r_prod);
            OP_BETA: r_bc  <= $signed(r_prod[BC_W-1:0]);
            default: ;
        endcase
        if (i_ctl.clr) begin
            r_acc <= '0;
        end
    end

    assign hi_term = $signed(r_sc[SC_W-1:16]);
    assign lo_term = $signed(r_bc[BC_W-1:8]);
    assign sum     = SUM_W'(hi_term) + SUM_W'(lo_term);

    always_comb begin
        if (sum > SAT_HI) begin
            o_total = 16'sh7fff;
        end else if (sum < SAT_LO) begin
            o_total = -16'sh8000;
        end else begin
            o_total = $signed(sum[VAL_W-1:0]);
        end
    end

endmodule

// ===== design/mma_ctrl.sv =====
// Sequencer: takes input items, issues store writes, read addresses and
// multiplier operations, and emits one result item per column. Depends on mma_pkg.
module mma_ctrl #(
    parameter int MAX_DIM = mma_pkg::MAX_DIM_DEF
) (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  logic                                          i_in_valid,
    input  mma_pkg::t_in_item                             i_in_data,
    output logic                                          o_in_stall,
    input  logic                                          i_transpose_a,
    input  logic                                          i_transpose_b,
    input  logic [mma_pkg::DIMCFG_W-1:0]                  i_rows_m,
    input  logic [mma_pkg::DIMCFG_W-1:0]                  i_cols_n,
    input  logic [mma_pkg::DIMCFG_W-1:0]                  i_inner_k,
    input  logic                                          i_out_free,
    input  logic signed [mma_pkg::VAL_W-1:0]              i_total,
    output mma_pkg::t_ctl                                 o_ctl,
    output logic [2*mma_pkg::dim_width(MAX_DIM)-1:0]      o_raddr_a,
    output logic [2*mma_pkg::dim_width(MAX_DIM)-1:0]      o_raddr_b,
    output logic [2*mma_pkg::dim_width(MAX_DIM)-1:0]      o_raddr_c,
    output logic                                          o_we_a,
    output logic                                          o_we_b,
    output logic                                          o_we_c,
    output logic [2*mma_pkg::dim_width(MAX_DIM)-1:0]      o_waddr,
    output logic signed [mma_pkg::VAL_W-1:0]              o_wdata,
    output logic                                          o_emit,
    output mma_pkg::t_out_item                            o_out_item
);
    import mma_pkg::*;

    localparam int DIM_W = dim_width(MAX_DIM);
    localparam int NCH   = chunk_count(MAX_DIM);
    localparam int LIM_N = (MAX_DIM < RESULT_LIMIT) ? MAX_DIM : RESULT_LIMIT;

    t_state                r_state, n_state;
    logic [IDX_W-1:0]      r_i, n_i;
    logic [IDX_W-1:0]      r_j, n_j;
    logic [DIMCFG_W-1:0]   r_t, n_t;
    logic [DIMCFG_W-1:0]   r_n, n_n;
    logic [DIMCFG_W-1:0]   r_k, n_k;

    logic [DIMCFG_W-1:0]   m_lim;
    logic [DIMCFG_W-1:0]   n_lim;
    logic [DIMCFG_W-1:0]   k_lim;
    logic                  in_range;
    logic                  last_col;

    assign m_lim = (int'(i_rows_m) > MAX_DIM) ? DIMCFG_W'(MAX_DIM) : i_rows_m;
    assign n_lim = (int'(i_cols_n) > LIM_N) ? DIMCFG_W'(LIM_N) : i_cols_n;
    assign k_lim = (int'(i_inner_k) > MAX_DIM) ? DIMCFG_W'(MAX_DIM) : i_inner_k;
    assign in_range = (int'(i_in_data.row) < MAX_DIM) && (int'(i_in_data.col) < MAX_DIM);
    assign last_col = ((DIMCFG_W'(r_j) + 7'd1) == r_n);

    assign o_in_stall = (r_state != S_IDLE);
    assign o_raddr_a  = i_transpose_a ? {DIM_W'(r_t), DIM_W'(r_i)} : {DIM_W'(r_i), DIM_W'(r_t)};
    assign o_raddr_b  = i_transpose_b ? {DIM_W'(r_j), DIM_W'(r_t)} : {DIM_W'(r_t), DIM_W'(r_j)};
    assign o_raddr_c  = {DIM_W'(r_i), DIM_W'(r_j)};
    assign o_out_item = '{out_row: r_i, out_col: r_j, out_value: i_total, last: last_col};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_i     <= '0;
            r_j     <= '0;
            r_t     <= '0;
            r_n     <= '0;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            r_i     <= n_i;
            r_j     <= n_j;
            r_t     <= n_t;
            r_n     <= n_n;
            r_k     <= n_k;
        end
    end

    always_comb begin
        n_state = r_state;
        n_i     = r_i;
        n_j     = r_j;
        n_t     = r_t;
        n_n     = r_n;
        n_k     = r_k;
        o_ctl   = '{op: OP_NONE, clr: 1'b0};
        o_we_a  = 1'b0;
        o_we_b  = 1'b0;
        o_we_c  = 1'b0;
        o_waddr = {DIM_W'(i_in_data.row), DIM_W'(i_in_data.col)};
        o_wdata = i_in_data.value;
        o_emit  = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    case (i_in_data.mode)
                        MODE_LOAD_A: o_we_a = in_range;
                        MODE_LOAD_B: o_we_b = in_range;
                        MODE_LOAD_C: o_we_c = in_range;
                        MODE_COMPUTE: begin
                            if (({1'b0, i_in_data.row} < m_lim) && (n_lim != '0)) begin
                                n_i     = i_in_data.row;
                                n_j     = '0;
                                n_n     = n_lim;
                                n_k     = k_lim;
                                n_state = S_START;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_START: begin
                o_ctl.clr = 1'b1;
                n_t       = '0;
                n_state   = (r_k == '0) ? S_DRAIN1 : S_MAC;
            end
            S_MAC: begin
                o_ctl.op = OP_MAC;
                if ((r_t + 7'd1) == r_k) begin
                    n_t     = '0;
                    n_state = S_DRAIN1;
                end else begin
                    n_t = r_t + 7'd1;
                end
            end
            S_DRAIN1: begin
                if (r_t == DRAIN_LAST) begin
                    n_t     = '0;
                    n_state = S_TOP;
                end else begin
                    n_t = r_t + 7'd1;
                end
            end
            S_TOP: begin
                o_ctl.op = OP_TOP;
                n_t      = '0;
                n_state  = S_LOW;
            end
            S_LOW: begin
                o_ctl.op = OP_LOW;
                if (r_t == DIMCFG_W'(NCH - 2)) begin
                    n_t     = '0;
                    n_state = S_BETA;
                end else begin
                    n_t = r_t + 7'd1;
                end
            end
            S_BETA: begin
                o_ctl.op = OP_BETA;
                n_t      = '0;
                n_state  = S_DRAIN2;
            end
            S_DRAIN2: begin
                if (r_t == DRAIN_LAST) begin
                    n_t     = '0;
                    n_state = S_OUT;
                end else begin
                    n_t = r_t + 7'd1;
                end
            end
            S_OUT: begin
                o_waddr = {DIM_W'(r_i), DIM_W'(r_j)};
                o_wdata = i_total;
                if (i_out_free) begin
                    o_emit = 1'b1;
                    o_we_c = 1'b1;
                    if (last_col) begin
                        n_state = S_IDLE;
                    end else begin
                        n_j     = r_j + 6'd1;
                        n_state = S_START;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

// ===== design/matrix_multiply_accumulate.sv =====
// Top level of the matrix multiply-accumulate block.
// Depends on mma_pkg, mma_ram, mma_dp and mma_ctrl.
//
// A load item (A, B or C element) is taken and the next item may follow at
// once. A compute item for a row below M, with N nonzero, is taken, then the
// block stalls its input while it produces the N results of that row, one
// column at a time, and also while the output is stalled. The single shared
// 17x17 multiplier does the K products (one A and one B read a cycle), three
// alpha partial products and the beta product of every column. A row at or
// beyond M is taken and gives no result. The stores need no clearing pass
// after reset; entries read before they are written are undefined.
module matrix_multiply_accumulate #(
    parameter int MAX_DIM = mma_pkg::MAX_DIM_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  mma_pkg::t_in_item                 i_in_data,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output mma_pkg::t_out_item                o_out_data,
    input  logic                              i_cfg_we,
    input  logic [mma_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [mma_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import mma_pkg::*;

    localparam int AW = 2 * dim_width(MAX_DIM);

    logic                        r_transpose_a;
    logic                        r_transpose_b;
    logic [DIMCFG_W-1:0]         r_rows_m;
    logic [DIMCFG_W-1:0]         r_cols_n;
    logic [DIMCFG_W-1:0]         r_inner_k;
    logic signed [VAL_W-1:0]     r_alpha;
    logic signed [VAL_W-1:0]     r_beta;
    logic                        r_out_valid;
    t_out_item                   r_out_data;

    t_ctl                        ctl;
    logic [AW-1:0]               raddr_a;
    logic [AW-1:0]               raddr_b;
    logic [AW-1:0]               raddr_c;
    logic [AW-1:0]               waddr;
    logic signed [VAL_W-1:0]     wdata;
    logic                        we_a;
    logic                        we_b;
    logic                        we_c;
    logic [VAL_W-1:0]            rd_a;
    logic [VAL_W-1:0]            rd_b;
    logic [VAL_W-1:0]            rd_c;
    logic signed [VAL_W-1:0]     total;
    logic                        emit;
    logic                        out_free;
    t_out_item                   out_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_transpose_a <= 1'b0;
            r_transpose_b <= 1'b0;
            r_rows_m      <= 7'd64;
            r_cols_n      <= 7'd64;
            r_inner_k     <= 7'd64;
            r_alpha       <= 16'sd256;
            r_beta        <= 16'sd0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_TRANSPOSE_A: r_transpose_a <= i_cfg_data[0];
                CFG_TRANSPOSE_B: r_transpose_b <= i_cfg_data[0];
                CFG_ROWS_M:      r_rows_m      <= i_cfg_data[DIMCFG_W-1:0];
                CFG_COLS_N:      r_cols_n      <= i_cfg_data[DIMCFG_W-1:0];
                CFG_INNER_K:     r_inner_k     <= i_cfg_data[DIMCFG_W-1:0];
                CFG_ALPHA:       r_alpha       <= $signed(i_cfg_data);
                CFG_BETA:        r_beta        <= $signed(i_cfg_data);
                default: ;
            endcase
        end
    end

    assign out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_data <= out_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    mma_ctrl #(
        .MAX_DIM(MAX_DIM)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_in_data     (i_in_data),
        .o_in_stall    (o_in_stall),
        .i_transpose_a (r_transpose_a),
        .i_transpose_b (r_transpose_b),
        .i_rows_m      (r_rows_m),
        .i_cols_n      (r_cols_n),
        .i_inner_k     (r_inner_k),
        .i_out_free    (out_free),
        .i_total       (total),
        .o_ctl         (ctl),
        .o_raddr_a     (raddr_a),
        .o_raddr_b     (raddr_b),
        .o_raddr_c     (raddr_c),
        .o_we_a        (we_a),
        .o_we_b        (we_b),
        .o_we_c        (we_c),
        .o_waddr       (waddr),
        .o_wdata       (wdata),
        .o_emit        (emit),
        .o_out_item    (out_item)
    );

    mma_ram #(
        .AW(AW),
        .DW(VAL_W)
    ) u_ram_a (
        .i_clk   (i_clk),
        .i_we    (we_a),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr_a),
        .o_rdata (rd_a)
    );

    mma_ram #(
        .AW(AW),
        .DW(VAL_W)
    ) u_ram_b (
        .i_clk   (i_clk),
        .i_we    (we_b),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr_b),
        .o_rdata (rd_b)
    );

    mma_ram #(
        .AW(AW),
        .DW(VAL_W)
    ) u_ram_c (
        .i_clk   (i_clk),
        .i_we    (we_c),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr_c),
        .o_rdata (rd_c)
    );

    mma_dp #(
        .MAX_DIM(MAX_DIM)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl),
        .i_rd_a  ($signed(rd_a)),
        .i_rd_b  ($signed(rd_b)),
        .i_rd_c  ($signed(rd_c)),
        .i_alpha (r_alpha),
        .i_beta  (r_beta),
        .o_total (total)
    );

endmodule
